>>> hw/rtl/stereo_frame_convert_resample_core_defines.svh
// Assertion helpers for the checker file.
`ifndef STEREO_FRAME_CONVERT_RESAMPLE_CORE_DEFINES_SVH
`define STEREO_FRAME_CONVERT_RESAMPLE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define SFCR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sfcr assertion failed");

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define SFCR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sfcr assertion failed");

`endif

>>> hw/rtl/sfcr_pkg.sv
package sfcr_pkg;

    localparam int RAW_W      = 32;
    localparam int SAMPLE_W   = 16;
    localparam int FMT_W      = 3;
    localparam int STEP_W     = 21;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 21;

    // sample format codes
    localparam logic [FMT_W-1:0] FMT_INT16   = 3'd0;
    localparam logic [FMT_W-1:0] FMT_INT24   = 3'd1;
    localparam logic [FMT_W-1:0] FMT_INT32   = 3'd2;
    localparam logic [FMT_W-1:0] FMT_FLOAT32 = 3'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_FORMAT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_MONO     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_MONO     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RESAMPLE_ENABLE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP      = 3'd4;

    localparam logic [STEP_W-1:0] STEP_RESET = 21'd65536;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

endpackage

>>> hw/rtl/sfcr_convert.sv
// Raw channel word to signed 16-bit sample.
module sfcr_convert
    import sfcr_pkg::*;
(
    input  logic [RAW_W-1:0] i_word,
    input  logic [FMT_W-1:0] i_format,
    output t_sample          o_sample
);

    logic [RAW_W-1:0] neg_word;
    t_sample          int32_val;
    logic             f_sign;
    logic [7:0]       f_expo;
    logic [23:0]      f_mant;
    logic [7:0]       f_shift;
    logic [23:0]      f_mag;
    t_sample          float_val;

    always_comb begin
        neg_word  = ~i_word + 32'd1;
        int32_val = i_word[31] ? (16'd0 - neg_word[31:16]) : i_word[31:16];

        f_sign  = i_word[31];
        f_expo  = i_word[30:23];
        f_mant  = {(f_expo != 8'd0), i_word[22:0]};
        f_shift = 8'd135 - f_expo;
        f_mag   = (f_shift >= 8'd24) ? 24'd0 : (f_mant >> f_shift[4:0]);

        if (f_expo == 8'hff) begin
            // NaN reads as silence, infinity saturates
            if (i_word[22:0] != 23'd0) begin
                float_val = '0;
            end else begin
                float_val = f_sign ? SAMPLE_MIN : SAMPLE_MAX;
            end
        end else if (f_expo >= 8'd135) begin
            float_val = f_sign ? SAMPLE_MIN : SAMPLE_MAX;
        end else if (f_sign) begin
            float_val = (f_mag >= 24'd32768) ? SAMPLE_MIN : (16'd0 - f_mag[15:0]);
        end else begin
            float_val = (f_mag > 24'd32767) ? SAMPLE_MAX : f_mag[15:0];
        end

        case (i_format)
            FMT_INT16:   o_sample = i_word[15:0];
            FMT_INT24:   o_sample = i_word[23:8];
            FMT_INT32:   o_sample = int32_val;
            FMT_FLOAT32: o_sample = float_val;
            default:     o_sample = '0;
        endcase
    end

endmodule

>>> hw/rtl/sfcr_interp.sv
// One interpolation lane: held + (cur - held) * frac, truncated toward zero.
// Product is registered; the add and round happen on the way to the output register.
module sfcr_interp
    import sfcr_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_load,
    input  t_sample              i_held,
    input  t_sample              i_cur,
    input  logic [FRAC_BITS-1:0] i_frac,
    output t_sample              o_sample
);

    localparam int PW = FRAC_BITS + 18;

    logic signed [16:0]        diff;
    logic signed [FRAC_BITS:0] frac_s;
    logic signed [PW-1:0]      n_prod;
    logic signed [PW-1:0]      r_prod;
    t_sample                   r_base;
    logic signed [PW-1:0]      num;
    logic signed [PW-1:0]      bias;
    logic signed [PW-1:0]      adj;

    always_comb begin
        diff   = {i_cur[15], i_cur} - {i_held[15], i_held};
        frac_s = $signed({1'b0, i_frac});
        n_prod = diff * frac_s;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= n_prod;
            r_base <= i_held;
        end
    end

    always_comb begin
        num  = $signed({{2{r_base[15]}}, r_base, {FRAC_BITS{1'b0}}}) + r_prod;
        bias = num[PW-1] ? $signed({{(PW-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}}) : '0;
        adj  = num + bias;
        o_sample = adj[FRAC_BITS+15:FRAC_BITS];
    end

endmodule

>>> hw/rtl/stereo_frame_convert_resample_core.sv
// Stereo frame converter with linear-interpolation rate conversion. Each input
// transaction carries one source frame (two raw channel words and a silent
// flag); both words are converted to signed 16 bits side by side by two
// converter lanes, then mapped for mono source / mono target. In bypass
// (resample_enable = 0) the frame is presented as one output transaction with
// last_of_run set once it has passed the raw-word, current-frame and output
// registers, and the next input is taken once the core is back in idle. With
// resampling on, the first frame after reset is only held; after that each
// input yields zero to MAX_RUN output frames, interpolated between the held
// and current frame at the Q.PHASE_FRAC_BITS phase. The two interpolation
// lanes register their product in the multiply state and the merge into the
// output register follows in the emit state, which waits while the output
// side stalls. The output register lets the next input transaction be taken
// while the final frame of a run is still waiting. Configuration is a plain
// write port and should only be written when the core is idle with no frame
// pending.
module stereo_frame_convert_resample_core
    import sfcr_pkg::*;
#(
    parameter int PHASE_FRAC_BITS = 16,
    parameter int MAX_RUN         = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // input frame
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [RAW_W-1:0]      i_first_raw,
    input  logic [RAW_W-1:0]      i_second_raw,
    input  logic                  i_silent,
    // output frame
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_sample               o_left_sample,
    output t_sample               o_right_sample,
    output logic                  o_last_of_run
);

    // phase must hold 1.0 plus a full step
    localparam int PW = ((PHASE_FRAC_BITS > STEP_W) ? PHASE_FRAC_BITS : STEP_W) + 1;
    localparam int CW = $clog2(MAX_RUN);
    localparam logic [PW-1:0] PHASE_ONE = PW'(1) << PHASE_FRAC_BITS;
    localparam logic [CW-1:0] RUN_LAST  = CW'(MAX_RUN - 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CONV = 3'd1;
    localparam logic [2:0] ST_BYP  = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    // configuration registers
    logic [FMT_W-1:0]  r_fmt;
    logic              r_src_mono;
    logic              r_tgt_mono;
    logic              r_rs_en;
    logic [STEP_W-1:0] r_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt      <= FMT_INT16;
            r_src_mono <= 1'b0;
            r_tgt_mono <= 1'b0;
            r_rs_en    <= 1'b0;
            r_step     <= STEP_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_SAMPLE_FORMAT:   r_fmt      <= i_cfg_wdata[FMT_W-1:0];
                CFG_SOURCE_MONO:     r_src_mono <= i_cfg_wdata[0];
                CFG_TARGET_MONO:     r_tgt_mono <= i_cfg_wdata[0];
                CFG_RESAMPLE_ENABLE: r_rs_en    <= i_cfg_wdata[0];
                CFG_PHASE_STEP:      r_step     <= i_cfg_wdata[STEP_W-1:0];
                default:             ;
            endcase
        end
    end

    // datapath and control registers
    logic [2:0]       r_state,     n_state;
    logic [RAW_W-1:0] r_first,     n_first;
    logic [RAW_W-1:0] r_second,    n_second;
    logic             r_silent,    n_silent;
    t_sample          r_cur_l,     n_cur_l;
    t_sample          r_cur_r,     n_cur_r;
    t_sample          r_held_l,    n_held_l;
    t_sample          r_held_r,    n_held_r;
    logic             r_have_held, n_have_held;
    logic [PW-1:0]    r_phase,     n_phase;
    logic [CW-1:0]    r_count,     n_count;
    logic             r_out_valid, n_out_valid;
    t_sample          r_out_l,     n_out_l;
    t_sample          r_out_r,     n_out_r;
    logic             r_out_last,  n_out_last;

    // converter lanes
    t_sample conv0;
    t_sample conv1;

    sfcr_convert u_conv0 (
        .i_word   (r_first),
        .i_format (r_fmt),
        .o_sample (conv0)
    );

    sfcr_convert u_conv1 (
        .i_word   (r_second),
        .i_format (r_fmt),
        .o_sample (conv1)
    );

    // channel mapping
    t_sample map_c0;
    t_sample map_c1;
    t_sample map_l;
    t_sample map_r;

    always_comb begin
        map_c0 = r_silent ? '0 : conv0;
        map_c1 = r_src_mono ? map_c0 : (r_silent ? '0 : conv1);
        map_l  = map_c0;
        map_r  = r_tgt_mono ? map_c0 : map_c1;
    end

    // interpolation lanes
    logic    lane_load;
    t_sample lerp_l;
    t_sample lerp_r;

    assign lane_load = (r_state == ST_MUL);

    sfcr_interp #(
        .FRAC_BITS (PHASE_FRAC_BITS)
    ) u_lerp_l (
        .i_clk    (i_clk),
        .i_load   (lane_load),
        .i_held   (r_held_l),
        .i_cur    (r_cur_l),
        .i_frac   (r_phase[PHASE_FRAC_BITS-1:0]),
        .o_sample (lerp_l)
    );

    sfcr_interp #(
        .FRAC_BITS (PHASE_FRAC_BITS)
    ) u_lerp_r (
        .i_clk    (i_clk),
        .i_load   (lane_load),
        .i_held   (r_held_r),
        .i_cur    (r_cur_r),
        .i_frac   (r_phase[PHASE_FRAC_BITS-1:0]),
        .o_sample (lerp_r)
    );

    // phase walk
    logic [PW-1:0] phase_sum;
    logic          sum_ge_one;
    logic          phase_ge_one;
    logic          run_last;
    logic          out_free;

    always_comb begin
        phase_sum    = r_phase + PW'(r_step);
        sum_ge_one   = (phase_sum[PW-1:PHASE_FRAC_BITS] != '0);
        phase_ge_one = (r_phase[PW-1:PHASE_FRAC_BITS] != '0);
        run_last     = sum_ge_one || (r_count == RUN_LAST);
        out_free     = !r_out_valid || i_out_ready;
    end

    always_comb begin
        n_state     = r_state;
        n_first     = r_first;
        n_second    = r_second;
        n_silent    = r_silent;
        n_cur_l     = r_cur_l;
        n_cur_r     = r_cur_r;
        n_held_l    = r_held_l;
        n_held_r    = r_held_r;
        n_have_held = r_have_held;
        n_phase     = r_phase;
        n_count     = r_count;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_l     = r_out_l;
        n_out_r     = r_out_r;
        n_out_last  = r_out_last;

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_first  = i_first_raw;
                    n_second = i_second_raw;
                    n_silent = i_silent;
                    n_state  = ST_CONV;
                end
            end
            ST_CONV: begin
                n_cur_l = map_l;
                n_cur_r = map_r;
                n_count = '0;
                if (!r_rs_en) begin
                    n_state = ST_BYP;
                end else if (!r_have_held) begin
                    // first frame only primes the history
                    n_held_l    = map_l;
                    n_held_r    = map_r;
                    n_have_held = 1'b1;
                    n_state     = ST_IDLE;
                end else if (phase_ge_one) begin
                    // downsampling: frame skipped
                    n_held_l = map_l;
                    n_held_r = map_r;
                    n_phase  = r_phase - PHASE_ONE;
                    n_state  = ST_IDLE;
                end else begin
                    n_state = ST_MUL;
                end
            end
            ST_BYP: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_l     = r_cur_l;
                    n_out_r     = r_cur_r;
                    n_out_last  = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            ST_MUL: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_l     = lerp_l;
                    n_out_r     = lerp_r;
                    n_out_last  = run_last;
                    n_count     = r_count + CW'(1);
                    if (run_last) begin
                        // run cap with phase short of 1.0 drops the rest
                        n_phase  = sum_ge_one ? (phase_sum - PHASE_ONE) : '0;
                        n_held_l = r_cur_l;
                        n_held_r = r_cur_r;
                        n_state  = ST_IDLE;
                    end else begin
                        n_phase = phase_sum;
                        n_state = ST_MUL;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_have_held <= 1'b0;
            r_phase     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_have_held <= n_have_held;
            r_phase     <= n_phase;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_first    <= n_first;
        r_second   <= n_second;
        r_silent   <= n_silent;
        r_cur_l    <= n_cur_l;
        r_cur_r    <= n_cur_r;
        r_held_l   <= n_held_l;
        r_held_r   <= n_held_r;
        r_out_l    <= n_out_l;
        r_out_r    <= n_out_r;
        r_out_last <= n_out_last;
    end

    // no transaction is taken while reset is held
    assign o_in_ready     = i_rst_n && (r_state == ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_left_sample  = r_out_l;
    assign o_right_sample = r_out_r;
    assign o_last_of_run  = r_out_last;

endmodule

>>> hw/rtl/sfcr_checker.sv
`include "stereo_frame_convert_resample_core_defines.svh"

// Port-level checks; tracks the mode bits from the config port.
module sfcr_checker
    import sfcr_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_cfg_wr_en,
    input logic [CFG_IDX_W-1:0]  i_cfg_index,
    input logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input t_sample               o_left_sample,
    input t_sample               o_right_sample,
    input logic                  o_last_of_run
);

    logic r_rs_en;
    logic r_tgt_mono;

    logic [2*SAMPLE_W:0] out_word;
    logic                byp_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rs_en    <= 1'b0;
            r_tgt_mono <= 1'b0;
        end else if (i_cfg_wr_en) begin
            if (i_cfg_index == CFG_RESAMPLE_ENABLE) begin
                r_rs_en <= i_cfg_wdata[0];
            end
            if (i_cfg_index == CFG_TARGET_MONO) begin
                r_tgt_mono <= i_cfg_wdata[0];
            end
        end
    end

    assign out_word = {o_left_sample, o_right_sample, o_last_of_run};
    assign byp_out  = o_out_valid && !r_rs_en;

    // stalled transaction holds
    `SFCR_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid)
    `SFCR_ASSERT_NXT(a_out_stable, o_out_valid && !i_out_ready, $stable(out_word))
    // bypass gives exactly one frame per input, so every one closes its run
    `SFCR_ASSERT_IMP(a_byp_last, byp_out, o_last_of_run)
    // mono target in bypass duplicates left into right
    `SFCR_ASSERT_IMP(a_byp_mono, byp_out && r_tgt_mono, o_left_sample == o_right_sample)

endmodule

bind stereo_frame_convert_resample_core sfcr_checker u_sfcr_checker (.*);
